[hdl/scs_pkg.sv]
// Shared types and constants for the sample-paced cycle scheduler.
// Used by scs_mul_acc, scs_div and sample_paced_cycle_scheduler; depends on nothing.
package scs_pkg;

  localparam int BASE_W = 28;
  localparam int REM_W  = 18;
  localparam int SR_W   = 18;
  localparam int CPU_W  = 28;
  localparam int VR_W   = 28;
  localparam int CYC_W  = 8;
  localparam int TICK_W = 16;
  localparam int DEBT_W = 8;
  localparam int RUN_W  = 29;
  localparam int TGT_W  = 29;
  localparam int NEED_W = BASE_W + 1;
  localparam int ACC_W  = CYC_W + VR_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 28;

  localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(416);
  localparam logic [REM_W-1:0]  REM_RST  = REM_W'(32000);
  localparam logic [SR_W-1:0]   SR_RST   = SR_W'(48000);
  localparam logic [CPU_W-1:0]  CPU_RST  = CPU_W'(20000000);
  localparam logic [VR_W-1:0]   VR_RST   = VR_W'(60);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_INSTR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_CYCLES     = 3'd0,
    CFG_CYCLE_REMAINDER = 3'd1,
    CFG_SAMPLE_RATE     = 3'd2,
    CFG_CPU_RATE        = 3'd3,
    CFG_VIDEO_RATE      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] acc;
  } mul_res_t;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] ticks;
    logic [CPU_W-1:0]  rem;
  } div_res_t;

endpackage

[hdl/scs_mul_acc.sv]
// Bit-serial multiply-accumulate: cycles times video rate plus the video fraction.
// Depends on scs_pkg.
module scs_mul_acc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [scs_pkg::CYC_W-1:0]     cyc,
  input  logic [scs_pkg::VR_W-1:0]      video_rate,
  input  logic [scs_pkg::CPU_W-1:0]     frac_in,
  output scs_pkg::mul_res_t             res
);

  localparam int CNT_W = $clog2(scs_pkg::CYC_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [scs_pkg::CYC_W-1:0]   cyc_r, cyc_nxt;
  logic [scs_pkg::ACC_W-1:0]   prod_r, prod_nxt;
  logic [scs_pkg::ACC_W-1:0]   addend;

  assign addend = cyc_r[scs_pkg::CYC_W-1]
                ? {{(scs_pkg::ACC_W-scs_pkg::VR_W){1'b0}}, video_rate}
                : '0;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    cyc_nxt  = cyc_r;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(scs_pkg::CYC_W);
      cyc_nxt  = cyc;
      prod_nxt = '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        prod_nxt = {prod_r[scs_pkg::ACC_W-2:0], 1'b0} + addend;
        cyc_nxt  = {cyc_r[scs_pkg::CYC_W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
      end else begin
        prod_nxt = prod_r + {{(scs_pkg::ACC_W-scs_pkg::CPU_W){1'b0}}, frac_in};
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      cyc_r  <= cyc_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign res.done = done_r;
  assign res.acc  = prod_r;

endmodule

[hdl/scs_div.sv]
// Bit-serial restoring divider giving a saturated 16-bit quotient and the remainder.
// Depends on scs_pkg.
module scs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [scs_pkg::ACC_W-1:0]   dividend,
  input  logic [scs_pkg::CPU_W-1:0]   divisor,
  output scs_pkg::div_res_t           res
);

  localparam int CNT_W = $clog2(scs_pkg::ACC_W + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [scs_pkg::ACC_W-1:0]     dvd_r, dvd_nxt;
  logic [scs_pkg::CPU_W-1:0]     rem_r, rem_nxt;
  logic [scs_pkg::TICK_W-1:0]    q_r, q_nxt;
  logic                          sat_r, sat_nxt;
  logic [scs_pkg::CPU_W:0]       trial;
  logic [scs_pkg::CPU_W:0]       diff;
  logic                          fits;

  assign trial = {rem_r, dvd_r[scs_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(scs_pkg::ACC_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      q_nxt    = '0;
      sat_nxt  = 1'b0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[scs_pkg::ACC_W-2:0], 1'b0};
      rem_nxt = fits ? diff[scs_pkg::CPU_W-1:0] : trial[scs_pkg::CPU_W-1:0];
      q_nxt   = {q_r[scs_pkg::TICK_W-2:0], fits};
      sat_nxt = sat_r | q_r[scs_pkg::TICK_W-1];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.ticks = sat_r ? '1 : q_r;
  assign res.rem   = rem_r;

endmodule

[hdl/sample_paced_cycle_scheduler.sv]
// Top level of the sample-paced cycle scheduler: pacing state, control and output register.
// Depends on scs_pkg, scs_mul_acc and scs_div.
//
// One item is worked on at a time and each item gives exactly one result. A sample-start
// item and an instruction report outside a sample window go from acceptance through the done
// state to the output register. An instruction report inside a window is accepted, then passes
// through the bit-serial multiplier and the bit-serial restoring divider that forms the video
// ticks, and is handed to the output register. The divider sets the rate.
// A new item is accepted as soon as the previous one has reached the output register, even
// while that result still waits to be taken.
module sample_paced_cycle_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [scs_pkg::CYC_W-1:0]         in_instr_cycles,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [scs_pkg::TICK_W-1:0]        out_video_ticks,
  output logic                              out_sample_ready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t                         state_r, state_nxt;
  logic [scs_pkg::BASE_W-1:0]     base_r, base_nxt;
  logic [scs_pkg::REM_W-1:0]      crem_r, crem_nxt;
  logic [scs_pkg::SR_W-1:0]       srate_r, srate_nxt;
  logic [scs_pkg::CPU_W-1:0]      cpu_r, cpu_nxt;
  logic [scs_pkg::VR_W-1:0]       vrate_r, vrate_nxt;
  logic [scs_pkg::REM_W-1:0]      sfrac_r, sfrac_nxt;
  logic [scs_pkg::CPU_W-1:0]      vfrac_r, vfrac_nxt;
  logic [scs_pkg::DEBT_W-1:0]     debt_r, debt_nxt;
  logic [scs_pkg::RUN_W-1:0]      run_r, run_nxt;
  logic [scs_pkg::TGT_W-1:0]      target_r, target_nxt;
  logic                           win_r, win_nxt;
  logic [scs_pkg::TICK_W-1:0]     res_ticks_r, res_ticks_nxt;
  logic                           res_ready_r, res_ready_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [scs_pkg::TICK_W-1:0]     out_ticks_r, out_ticks_nxt;
  logic                           out_ready_r, out_ready_nxt;

  logic [scs_pkg::REM_W:0]        sum19;
  logic [scs_pkg::REM_W:0]        sum_adj;
  logic                           wrap;
  logic [scs_pkg::NEED_W-1:0]     need;
  logic [scs_pkg::RUN_W:0]        run_sum;
  logic [scs_pkg::RUN_W-1:0]      run_new;
  logic [scs_pkg::RUN_W-1:0]      over;
  logic                           mul_start;
  logic                           div_start;
  scs_pkg::mul_res_t              mul_res;
  scs_pkg::div_res_t              div_res;

  assign sum19   = {1'b0, sfrac_r} + {1'b0, crem_r};
  assign wrap    = sum19 >= {1'b0, srate_r};
  assign sum_adj = wrap ? (sum19 - {1'b0, srate_r}) : sum19;
  assign need    = {1'b0, base_r} + {{(scs_pkg::NEED_W-1){1'b0}}, wrap};
  assign run_sum = {1'b0, run_r} + {{(scs_pkg::RUN_W+1-scs_pkg::CYC_W){1'b0}}, in_instr_cycles};
  assign run_new = run_sum[scs_pkg::RUN_W-1:0];
  assign over    = run_new - target_r;

  scs_mul_acc u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .cyc        (in_instr_cycles),
    .video_rate (vrate_r),
    .frac_in    (vfrac_r),
    .res        (mul_res)
  );

  scs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_res.acc),
    .divisor  (cpu_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    crem_nxt      = crem_r;
    srate_nxt     = srate_r;
    cpu_nxt       = cpu_r;
    vrate_nxt     = vrate_r;
    sfrac_nxt     = sfrac_r;
    vfrac_nxt     = vfrac_r;
    debt_nxt      = debt_r;
    run_nxt       = run_r;
    target_nxt    = target_r;
    win_nxt       = win_r;
    res_ticks_nxt = res_ticks_r;
    res_ready_nxt = res_ready_r;
    out_valid_nxt = out_valid_r;
    out_ticks_nxt = out_ticks_r;
    out_ready_nxt = out_ready_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_ticks_nxt = '0;
          res_ready_nxt = 1'b0;
          state_nxt     = S_DONE;
          if (in_req_type == scs_pkg::REQ_START) begin
            sfrac_nxt = sum_adj[scs_pkg::REM_W-1:0];
            run_nxt   = '0;
            if (need > {{(scs_pkg::NEED_W-scs_pkg::DEBT_W){1'b0}}, debt_r}) begin
              target_nxt = need - {{(scs_pkg::NEED_W-scs_pkg::DEBT_W){1'b0}}, debt_r};
              win_nxt    = 1'b1;
            end else begin
              debt_nxt      = debt_r - need[scs_pkg::DEBT_W-1:0];
              target_nxt    = '0;
              win_nxt       = 1'b0;
              res_ready_nxt = 1'b1;
            end
          end else if (win_r) begin
            run_nxt   = run_new;
            mul_start = 1'b1;
            state_nxt = S_MUL;
            if (run_new >= target_r) begin
              debt_nxt      = (over > scs_pkg::RUN_W'(255)) ? '1 : over[scs_pkg::DEBT_W-1:0];
              win_nxt       = 1'b0;
              res_ready_nxt = 1'b1;
            end
          end
        end
      end
      S_MUL: begin
        if (mul_res.done) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (cpu_r == '0) begin
            res_ticks_nxt = '1;
            vfrac_nxt     = '0;
          end else begin
            res_ticks_nxt = div_res.ticks;
            vfrac_nxt     = div_res.rem;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ticks_nxt = res_ticks_r;
          out_ready_nxt = res_ready_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      case (scs_pkg::cfg_idx_t'(cfg_index))
        scs_pkg::CFG_BASE_CYCLES:     base_nxt  = cfg_data[scs_pkg::BASE_W-1:0];
        scs_pkg::CFG_CYCLE_REMAINDER: crem_nxt  = cfg_data[scs_pkg::REM_W-1:0];
        scs_pkg::CFG_SAMPLE_RATE:     srate_nxt = cfg_data[scs_pkg::SR_W-1:0];
        scs_pkg::CFG_CPU_RATE:        cpu_nxt   = cfg_data[scs_pkg::CPU_W-1:0];
        scs_pkg::CFG_VIDEO_RATE:      vrate_nxt = cfg_data[scs_pkg::VR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= scs_pkg::BASE_RST;
      crem_r      <= scs_pkg::REM_RST;
      srate_r     <= scs_pkg::SR_RST;
      cpu_r       <= scs_pkg::CPU_RST;
      vrate_r     <= scs_pkg::VR_RST;
      sfrac_r     <= '0;
      vfrac_r     <= '0;
      debt_r      <= '0;
      run_r       <= '0;
      target_r    <= '0;
      win_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      crem_r      <= crem_nxt;
      srate_r     <= srate_nxt;
      cpu_r       <= cpu_nxt;
      vrate_r     <= vrate_nxt;
      sfrac_r     <= sfrac_nxt;
      vfrac_r     <= vfrac_nxt;
      debt_r      <= debt_nxt;
      run_r       <= run_nxt;
      target_r    <= target_nxt;
      win_r       <= win_nxt;
      res_ticks_r <= res_ticks_nxt;
      res_ready_r <= res_ready_nxt;
      out_valid_r <= out_valid_nxt;
      out_ticks_r <= out_ticks_nxt;
      out_ready_r <= out_ready_nxt;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_video_ticks  = out_ticks_r;
  assign out_sample_ready = out_ready_r;

  a_win_target: assert property (@(posedge clk) disable iff (!rst_n)
    win_r |-> (target_r != '0))
    else $error("sample window open with a zero cycle target");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_res.done |-> (state_r == S_MUL))
    else $error("multiplier finished outside the multiply state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_result_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || !out_stall)) |=> (out_valid && state_r == S_IDLE))
    else $error("finished item was not moved to the output register");

endmodule

[sim/tb_sample_paced_cycle_scheduler.sv]
// Self-checking testbench for sample_paced_cycle_scheduler: directed and random pacing items
// are checked against an in-bench prediction of the sample target, the debt and the video ticks.
// Depends on scs_pkg and the scheduler RTL.
module tb_sample_paced_cycle_scheduler;

  localparam int TARGET_W = scs_pkg::TGT_W + 1;
  localparam int VACC_W = scs_pkg::CYC_W + scs_pkg::VR_W;
  localparam logic [scs_pkg::CFG_DATA_W-1:0] REM_MAX = scs_pkg::CFG_DATA_W'(262143);
  localparam logic [scs_pkg::CFG_DATA_W-1:0] SR_MAX = scs_pkg::CFG_DATA_W'(262143);
  localparam logic [scs_pkg::CFG_DATA_W-1:0] RATE_MAX = 28'hFFFFFFF;
  localparam int MAX_WAIT = 14;

  typedef struct {
    logic [scs_pkg::TICK_W-1:0] ticks;
    logic                       ready;
  } pacing_res_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_req_type = scs_pkg::REQ_START;
  logic [scs_pkg::CYC_W-1:0]      in_instr_cycles = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [scs_pkg::TICK_W-1:0]     out_video_ticks;
  logic                           out_sample_ready;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [scs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [scs_pkg::BASE_W-1:0]   base_r = scs_pkg::BASE_RST;
  logic [scs_pkg::REM_W-1:0]    rem_r = scs_pkg::REM_RST;
  logic [scs_pkg::SR_W-1:0]     srate_r = scs_pkg::SR_RST;
  logic [scs_pkg::CPU_W-1:0]    cpu_r = scs_pkg::CPU_RST;
  logic [scs_pkg::VR_W-1:0]     vrate_r = scs_pkg::VR_RST;
  logic [scs_pkg::REM_W-1:0]    phase_acc = '0;
  logic [VACC_W-1:0]            vid_acc = '0;
  logic [scs_pkg::DEBT_W-1:0]   debt = '0;
  logic [scs_pkg::RUN_W-1:0]    run_cnt = '0;
  logic [TARGET_W-1:0]          target = '0;
  logic                         in_window = 1'b0;

  pacing_res_t pacing_q[$];
  int          mismatches = 0;
  int          hold_left = 0;
  bit          idle_on = 1'b1;

  sample_paced_cycle_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_instr_cycles  (in_instr_cycles),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_video_ticks  (out_video_ticks),
    .out_sample_ready (out_sample_ready),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void advance_pacing(logic req, logic [scs_pkg::CYC_W-1:0] cyc);
    logic [scs_pkg::REM_W:0]    sum;
    logic [scs_pkg::NEED_W-1:0] need;
    logic [scs_pkg::ACC_W-1:0]  acc;
    logic [scs_pkg::ACC_W-1:0]  quo;
    logic [scs_pkg::RUN_W-1:0]  over;
    pacing_res_t                res;
    res.ticks = '0;
    res.ready = 1'b0;
    if (req == scs_pkg::REQ_START) begin
      sum = {1'b0, phase_acc} + {1'b0, rem_r};
      need = {1'b0, base_r};
      if (sum >= {1'b0, srate_r}) begin
        need = need + 1'b1;
        sum = sum - {1'b0, srate_r};
      end
      phase_acc = sum[scs_pkg::REM_W-1:0];
      run_cnt = '0;
      if (need > scs_pkg::NEED_W'(debt)) begin
        target = TARGET_W'(need) - TARGET_W'(debt);
        in_window = 1'b1;
      end else begin
        debt = debt - need[scs_pkg::DEBT_W-1:0];
        target = '0;
        in_window = 1'b0;
        res.ready = 1'b1;
      end
    end else if (in_window) begin
      acc = scs_pkg::ACC_W'(vid_acc) + scs_pkg::ACC_W'(cyc) * scs_pkg::ACC_W'(vrate_r);
      if (cpu_r == '0) begin
        res.ticks = '1;
        vid_acc = '0;
      end else begin
        quo = acc / scs_pkg::ACC_W'(cpu_r);
        vid_acc = VACC_W'(acc % scs_pkg::ACC_W'(cpu_r));
        res.ticks = (quo > scs_pkg::ACC_W'(16'hFFFF)) ? '1 : quo[scs_pkg::TICK_W-1:0];
      end
      run_cnt = run_cnt + scs_pkg::RUN_W'(cyc);
      if (TARGET_W'(run_cnt) >= target) begin
        over = run_cnt - target[scs_pkg::RUN_W-1:0];
        debt = (over > scs_pkg::RUN_W'(255)) ? '1 : over[scs_pkg::DEBT_W-1:0];
        in_window = 1'b0;
        res.ready = 1'b1;
      end
    end
    pacing_q.push_back(res);
  endfunction

  task automatic send_item(logic req, logic [scs_pkg::CYC_W-1:0] cyc);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_instr_cycles <= cyc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_pacing(req, cyc);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pacing_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(scs_pkg::cfg_idx_t idx, logic [scs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      scs_pkg::CFG_BASE_CYCLES:     base_r = val[scs_pkg::BASE_W-1:0];
      scs_pkg::CFG_CYCLE_REMAINDER: rem_r = val[scs_pkg::REM_W-1:0];
      scs_pkg::CFG_SAMPLE_RATE:     srate_r = val[scs_pkg::SR_W-1:0];
      scs_pkg::CFG_CPU_RATE:        cpu_r = val[scs_pkg::CPU_W-1:0];
      scs_pkg::CFG_VIDEO_RATE:      vrate_r = val[scs_pkg::VR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_rates(int unsigned base, int unsigned rem, int unsigned srate,
                               int unsigned cpu, int unsigned vrate);
    wait_idle();
    write_reg(scs_pkg::CFG_BASE_CYCLES, scs_pkg::CFG_DATA_W'(base));
    write_reg(scs_pkg::CFG_CYCLE_REMAINDER, scs_pkg::CFG_DATA_W'(rem));
    write_reg(scs_pkg::CFG_SAMPLE_RATE, scs_pkg::CFG_DATA_W'(srate));
    write_reg(scs_pkg::CFG_CPU_RATE, scs_pkg::CFG_DATA_W'(cpu));
    write_reg(scs_pkg::CFG_VIDEO_RATE, scs_pkg::CFG_DATA_W'(vrate));
  endtask

  task automatic send_random_item();
    int unsigned               pick;
    logic [scs_pkg::CYC_W-1:0] cyc;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0:       cyc = '0;
      1:       cyc = '1;
      default: cyc = scs_pkg::CYC_W'($urandom_range(1, 255));
    endcase
    if (pick < 8) begin
      send_item(1'($urandom_range(0, 1)), cyc);
    end else begin
      send_item(in_window ? scs_pkg::REQ_INSTR : scs_pkg::REQ_START, cyc);
    end
  endtask

  // Reset rates: an ignored report, zero cycles, a dropped window and a completed one.
  task automatic test_reset_rates();
    send_item(scs_pkg::REQ_INSTR, 8'd255);
    send_item(scs_pkg::REQ_START, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd1);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
    send_item(scs_pkg::REQ_START, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd10);
    send_item(scs_pkg::REQ_START, 8'd170);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
  endtask

  // Rate extremes: zero base and sample rate, zero cpu rate, saturated ticks, huge target.
  task automatic test_rate_extremes();
    program_rates(0, REM_MAX, 0, 0, RATE_MAX);
    send_item(scs_pkg::REQ_START, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
    send_item(scs_pkg::REQ_START, 8'd0);
    send_item(scs_pkg::REQ_START, 8'd0);
    program_rates(3, REM_MAX, 1000, 1, RATE_MAX);
    send_item(scs_pkg::REQ_START, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
    send_item(scs_pkg::REQ_START, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd200);
    program_rates(RATE_MAX, REM_MAX, SR_MAX, RATE_MAX, RATE_MAX);
    send_item(scs_pkg::REQ_START, 8'd0);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
    send_item(scs_pkg::REQ_INSTR, 8'd255);
  endtask

  task automatic test_random_pacing();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: program_rates(scs_pkg::BASE_RST, scs_pkg::REM_RST, scs_pkg::SR_RST,
                         scs_pkg::CPU_RST, scs_pkg::VR_RST);
        2: program_rates(20, REM_MAX, SR_MAX, RATE_MAX, RATE_MAX);
        3: program_rates(1, 0, 1, 1, 1);
        4: program_rates($urandom_range(0, 300), $urandom_range(0, REM_MAX), 0, 0,
                         $urandom_range(1, RATE_MAX));
        5: program_rates(RATE_MAX, $urandom_range(0, REM_MAX), $urandom_range(1, SR_MAX),
                         $urandom_range(1, 1000), $urandom_range(1, RATE_MAX));
        default: program_rates($urandom_range(0, 600), $urandom_range(0, REM_MAX),
                               $urandom_range(1, SR_MAX), $urandom_range(1, RATE_MAX),
                               $urandom_range(1, RATE_MAX));
      endcase
      idle_on = (phase % 3) != 2;
      for (int k = 0; k < 106; k++) send_random_item();
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (out_valid === 1'b1 && hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pacing_res_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      hold_left <= idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (pacing_q.size() == 0) begin
        $error("Result with no item pending: video_ticks %0d sample_ready %0d",
               out_video_ticks, out_sample_ready);
        mismatches++;
      end else begin
        exp_r = pacing_q.pop_front();
        if (out_video_ticks !== exp_r.ticks) begin
          $error("video_ticks expected %0d actual %0d", exp_r.ticks, out_video_ticks);
          mismatches++;
        end
        if (out_sample_ready !== exp_r.ready) begin
          $error("sample_ready expected %0d actual %0d", exp_r.ready, out_sample_ready);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_rates();
    test_rate_extremes();
    test_random_pacing();
    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
